@@ sv/assert_macros.svh @@
// Assertion macros for the RTL; used by detection_proposal_filter_top.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CHECK_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Check that a condition implies another one in the following cycle.
`define CHECK_NEXT(label, clk, rst, cond, next) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (next)) \
      else $error("%m: check failed");

`endif

@@ sv/dpf_pkg.sv @@
// Types and constants for the detection proposal filter.
// No dependencies; imported by detection_proposal_filter_top.
`default_nettype none

package dpf_pkg;

   localparam int POS_BITS   = 9;
   localparam int THR_BITS   = 17;
   localparam int ATTR_BITS  = 32;
   localparam int CLASS_BITS = 8;
   localparam int BOX_BITS   = 16;
   localparam int SCORE_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCORE_THRESHOLD    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTRIBUTES_PER_ROW = 2'd1;

   localparam logic [THR_BITS-1:0] THR_RESET = 17'd16384;
   localparam logic [POS_BITS-1:0] LEN_RESET = 9'd85;
   localparam logic [POS_BITS-1:0] LEN_MIN   = 9'd6;

   // attribute positions within a row
   localparam logic [POS_BITS-1:0] POS_CENTER_X   = 9'd0;
   localparam logic [POS_BITS-1:0] POS_CENTER_Y   = 9'd1;
   localparam logic [POS_BITS-1:0] POS_WIDTH      = 9'd2;
   localparam logic [POS_BITS-1:0] POS_HEIGHT     = 9'd3;
   localparam logic [POS_BITS-1:0] POS_OBJECTNESS = 9'd4;
   localparam logic [POS_BITS-1:0] POS_FIRST_CLASS = 9'd5;

   typedef logic signed [ATTR_BITS-1:0] attr_type;

   // row captured on its last attribute
   typedef struct packed {
      attr_type               center_x;
      attr_type               center_y;
      attr_type               raw_width;
      attr_type               raw_height;
      attr_type               objectness;
      attr_type               best_score;
      logic [CLASS_BITS-1:0]  best_class;
   } row_type;

   // decoded box waiting for the score test
   typedef struct packed {
      logic signed [BOX_BITS-1:0]    box_left;
      logic signed [BOX_BITS-1:0]    box_top;
      logic signed [BOX_BITS-1:0]    box_width;
      logic signed [BOX_BITS-1:0]    box_height;
      logic signed [2*ATTR_BITS-1:0] product;
      logic                          obj_pass;
      logic [CLASS_BITS-1:0]         best_class;
   } box_type;

   function automatic logic signed [BOX_BITS-1:0] sat_box(input logic signed [BOX_BITS:0] v);
      logic signed [BOX_BITS-1:0] r;
      if (v[BOX_BITS] != v[BOX_BITS-1]) begin
         r = v[BOX_BITS] ? {1'b1, {(BOX_BITS-1){1'b0}}} : {1'b0, {(BOX_BITS-1){1'b1}}};
      end else begin
         r = v[BOX_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/detection_proposal_filter_top.sv @@
// Streaming decode and score filter for detector proposals.
// Depends on dpf_pkg and assert_macros.svh.
`default_nettype none

// One attribute is taken per cycle while req_stall is low, with no gaps between
// rows. The row state updates on each transfer; on a row's last attribute the
// row is captured in s2, then s3 registers the box and the 32x32 objectness-
// by-class product, and the threshold test loads the rsp_ result register that
// holds a passing row's box. Rows that fail the tests give no result. req_stall
// rises only when a captured row cannot move on because earlier results are
// held on a stalled rsp_ channel.
module detection_proposal_filter_top #(
   parameter int MAX_CLASSES = 256,
   parameter int VALUE_BITS  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [VALUE_BITS-1:0]        req_attr_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [dpf_pkg::BOX_BITS-1:0]      rsp_box_left,
   output logic signed [dpf_pkg::BOX_BITS-1:0]      rsp_box_top,
   output logic signed [dpf_pkg::BOX_BITS-1:0]      rsp_box_width,
   output logic signed [dpf_pkg::BOX_BITS-1:0]      rsp_box_height,
   output logic [dpf_pkg::SCORE_BITS-1:0]           rsp_det_score,
   output logic [dpf_pkg::CLASS_BITS-1:0]           rsp_class_index,
   input  wire logic                                csr_write_en,
   input  wire logic [dpf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [dpf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import dpf_pkg::*;

   localparam int LEN_MAX  = 5 + MAX_CLASSES;
   localparam int EXT_BITS = (VALUE_BITS > ATTR_BITS) ? VALUE_BITS : ATTR_BITS + 1;
   localparam logic signed [EXT_BITS-1:0] ATTR_MAX =
      EXT_BITS'({1'b0, {(ATTR_BITS-1){1'b1}}});
   localparam logic signed [EXT_BITS-1:0] ATTR_MIN =
      -EXT_BITS'({1'b1, {(ATTR_BITS-1){1'b0}}});

   // configuration
   logic [THR_BITS-1:0] thr_ff;
   logic [POS_BITS-1:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         len_ff <= LEN_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCORE_THRESHOLD:    thr_ff <= csr_wdata[THR_BITS-1:0];
            CSR_ATTRIBUTES_PER_ROW: len_ff <= csr_wdata[POS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // row state
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   attr_type              cx_ff, cy_ff, w_ff, h_ff, obj_ff, best_ff;
   attr_type              cx_in, cy_in, w_in, h_in, obj_in, best_in;
   logic [CLASS_BITS-1:0] class_ff, class_in;
   logic [POS_BITS-1:0]   len_eff;
   logic signed [EXT_BITS-1:0] value_ext;
   attr_type              value;
   logic                  row_last;
   logic                  req_take;

   // pipeline
   logic    s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   row_type s2_ff;
   box_type s3_ff, s3_in;
   logic    s2_ready, s3_ready, s3_go, out_ready, score_pass;
   logic signed [2*ATTR_BITS-1:0] thr_wide;
   logic [SCORE_BITS-1:0] score_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign thr_wide  = (2*ATTR_BITS)'({thr_ff, 16'b0});
   assign score_pass = s3_ff.obj_pass && (s3_ff.product >= thr_wide);
   assign s3_go     = s3_valid_ff && (!score_pass || out_ready);
   assign s3_ready  = !s3_valid_ff || s3_go;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign req_stall = !s2_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (len_ff < LEN_MIN) begin
         len_eff = LEN_MIN;
      end else if (len_ff > POS_BITS'(LEN_MAX)) begin
         len_eff = POS_BITS'(LEN_MAX);
      end else begin
         len_eff = len_ff;
      end
      row_last = ({1'b0, pos_ff} + 10'd1) >= {1'b0, len_eff};
      pos_in   = row_last ? '0 : pos_ff + 9'd1;

      value_ext = EXT_BITS'(req_attr_value);
      if (value_ext > ATTR_MAX) begin
         value = {1'b0, {(ATTR_BITS-1){1'b1}}};
      end else if (value_ext < ATTR_MIN) begin
         value = {1'b1, {(ATTR_BITS-1){1'b0}}};
      end else begin
         value = value_ext[ATTR_BITS-1:0];
      end

      cx_in    = cx_ff;
      cy_in    = cy_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      obj_in   = obj_ff;
      best_in  = best_ff;
      class_in = class_ff;
      case (pos_ff)
         POS_CENTER_X:    cx_in  = value;
         POS_CENTER_Y:    cy_in  = value;
         POS_WIDTH:       w_in   = value;
         POS_HEIGHT:      h_in   = value;
         POS_OBJECTNESS:  obj_in = value;
         POS_FIRST_CLASS: begin
            best_in  = value;
            class_in = '0;
         end
         default: begin
            // keep the first maximum: replace only on strictly greater
            if (value > best_ff) begin
               best_in  = value;
               class_in = CLASS_BITS'(pos_ff - POS_FIRST_CLASS);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (req_take) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         obj_ff   <= obj_in;
         best_ff  <= best_in;
         class_ff <= class_in;
      end
   end

   // capture the finished row
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= req_take && row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && row_last) begin
         s2_ff <= '{center_x: cx_in, center_y: cy_in, raw_width: w_in,
                    raw_height: h_in, objectness: obj_in, best_score: best_in,
                    best_class: class_in};
      end
   end

   // box decode and product
   logic signed [ATTR_BITS+1:0] dx, dy, dx_adj, dy_adj;
   attr_type                    w_adj, h_adj;

   always_comb begin
      dx = (ATTR_BITS+2)'(s2_ff.center_x) * 2 - (ATTR_BITS+2)'(s2_ff.raw_width);
      dy = (ATTR_BITS+2)'(s2_ff.center_y) * 2 - (ATTR_BITS+2)'(s2_ff.raw_height);
      // bias negatives so the shift truncates toward zero
      dx_adj = dx + (dx[ATTR_BITS+1] ? (ATTR_BITS+2)'(131071) : '0);
      dy_adj = dy + (dy[ATTR_BITS+1] ? (ATTR_BITS+2)'(131071) : '0);
      w_adj  = s2_ff.raw_width  + (s2_ff.raw_width[ATTR_BITS-1]  ? 32'sd65535 : '0);
      h_adj  = s2_ff.raw_height + (s2_ff.raw_height[ATTR_BITS-1] ? 32'sd65535 : '0);

      s3_in.box_left   = sat_box(dx_adj[ATTR_BITS+1:17]);
      s3_in.box_top    = sat_box(dy_adj[ATTR_BITS+1:17]);
      s3_in.box_width  = w_adj[ATTR_BITS-1:16];
      s3_in.box_height = h_adj[ATTR_BITS-1:16];
      s3_in.product    = (2*ATTR_BITS)'(s2_ff.objectness) *
                         (2*ATTR_BITS)'(s2_ff.best_score);
      s3_in.obj_pass   = (ATTR_BITS+1)'(s2_ff.objectness) >=
                         signed'((ATTR_BITS+1)'(thr_ff));
      s3_in.best_class = s2_ff.best_class;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   // threshold and result register
   always_comb begin
      if (s3_ff.product[2*ATTR_BITS-1]) begin
         score_in = '0;
      end else if (|s3_ff.product[2*ATTR_BITS-2:SCORE_BITS+16]) begin
         score_in = '1;
      end else begin
         score_in = s3_ff.product[SCORE_BITS+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s3_valid_ff && score_pass;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid_ff && score_pass) begin
         rsp_box_left    <= s3_ff.box_left;
         rsp_box_top     <= s3_ff.box_top;
         rsp_box_width   <= s3_ff.box_width;
         rsp_box_height  <= s3_ff.box_height;
         rsp_det_score   <= score_in;
         rsp_class_index <= s3_ff.best_class;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "assert_macros.svh"

   `CHECK_ALWAYS(a_pos_in_row, clock, reset, pos_ff < POS_BITS'(LEN_MAX))
   `CHECK_ALWAYS(a_stall_needs_row, clock, reset, !req_stall || (s2_valid_ff && s3_valid_ff))
   `CHECK_NEXT(a_result_from_s3, clock, reset, !s3_valid_ff && !rsp_valid_ff, !rsp_valid_ff)
   `CHECK_NEXT(a_last_captured, clock, reset, req_take && row_last, s2_valid_ff)

endmodule

`default_nettype wire

@@ bench/detection_proposal_filter_top_tb.sv @@
// Self-checking bench for detection_proposal_filter_top: streams proposal rows,
// predicts the surviving boxes in a small scoreboard class and checks each one.
// Depends on dpf_pkg and the RTL of detection_proposal_filter_top.

module detection_proposal_filter_top_tb;
   import dpf_pkg::*;

   localparam int MAX_CLASSES  = 256;
   localparam int N_ITEMS      = 1850;
   localparam int IDLE_LIMIT   = 3000;
   localparam int LONG_HOLD    = 400;
   localparam int PIPE_LATENCY = 3;
   localparam int PRESSURE_PHASE = 6;
   localparam int MAX_REPORTS  = 10;

   // indexes past the register list; writes there must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   localparam attr_type ONE_Q16  = 32'sh0001_0000;
   localparam attr_type ATTR_MAX = 32'sh7FFF_FFFF;
   localparam attr_type ATTR_MIN = 32'sh8000_0000;

   typedef enum int {ROW_PASS, ROW_MIXED, ROW_NOISE} row_kind_type;

   typedef struct packed {
      logic signed [BOX_BITS-1:0] left;
      logic signed [BOX_BITS-1:0] top;
      logic signed [BOX_BITS-1:0] width;
      logic signed [BOX_BITS-1:0] height;
      logic [SCORE_BITS-1:0]      score;
      logic [CLASS_BITS-1:0]      cls_index;
   } box_result_type;

   class box_scoreboard;
      logic [THR_BITS-1:0]   threshold  = THR_RESET;
      logic [POS_BITS-1:0]   row_length = LEN_RESET;
      logic [POS_BITS-1:0]   position   = '0;
      longint                center_x, center_y, raw_width, raw_height;
      longint                objectness, best_score;
      logic [CLASS_BITS-1:0] best_class = '0;
      box_result_type        expected_boxes[$];
      int                    mismatches = 0;

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_SCORE_THRESHOLD:    threshold = data[THR_BITS-1:0];
            CSR_ATTRIBUTES_PER_ROW: row_length = data[POS_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [BOX_BITS-1:0] clamp_box(longint v);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[BOX_BITS-1:0];
      endfunction

      function int pending();
         return expected_boxes.size();
      endfunction

      // advance the row state by one accepted attribute, queue a box on a passing row end
      function void take_attr(attr_type value);
         longint         v, thr, prod, scaled;
         int             len, pos;
         box_result_type box;
         v   = value;
         thr = threshold;
         pos = position;
         len = row_length;
         if (len < LEN_MIN) len = LEN_MIN;
         if (len > POS_FIRST_CLASS + MAX_CLASSES) len = POS_FIRST_CLASS + MAX_CLASSES;
         case (position)
            POS_CENTER_X:   center_x = v;
            POS_CENTER_Y:   center_y = v;
            POS_WIDTH:      raw_width = v;
            POS_HEIGHT:     raw_height = v;
            POS_OBJECTNESS: objectness = v;
            POS_FIRST_CLASS: begin
               best_score = v;
               best_class = '0;
            end
            default: begin
               // strict compare keeps the first of equal scores
               if (v > best_score) begin
                  best_score = v;
                  best_class = CLASS_BITS'(pos - POS_FIRST_CLASS);
               end
            end
         endcase
         if (pos + 1 < len) begin
            position = position + 1'b1;
            return;
         end
         position = '0;
         if (objectness < thr) return;
         prod = objectness * best_score;
         if (prod < thr * 65536) return;
         box.left      = clamp_box((2 * center_x - raw_width) / 131072);
         box.top       = clamp_box((2 * center_y - raw_height) / 131072);
         box.width     = clamp_box(raw_width / 65536);
         box.height    = clamp_box(raw_height / 65536);
         scaled        = (prod < 0) ? 0 : (prod >>> 16);
         if (scaled > 64'sh0000_0000_FFFF_FFFF) scaled = 64'sh0000_0000_FFFF_FFFF;
         box.score     = scaled[SCORE_BITS-1:0];
         box.cls_index = best_class;
         expected_boxes = {expected_boxes, box};
      endfunction

      function void check_box(box_result_type got);
         box_result_type want;
         if (expected_boxes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected box: left %0d top %0d width %0d height %0d score %h class %0d",
                        got.left, got.top, got.width, got.height, got.score, got.cls_index);
            return;
         end
         want = expected_boxes.pop_front();
         if (got.left !== want.left || got.top !== want.top || got.width !== want.width ||
             got.height !== want.height || got.score !== want.score ||
             got.cls_index !== want.cls_index) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("box mismatch: expected left %0d top %0d width %0d height %0d score %h class %0d",
                        want.left, want.top, want.width, want.height, want.score, want.cls_index);
               $display("                   got left %0d top %0d width %0d height %0d score %h class %0d",
                        got.left, got.top, got.width, got.height, got.score, got.cls_index);
            end
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   attr_type                       req_attr_value;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic signed [BOX_BITS-1:0]     rsp_box_left;
   logic signed [BOX_BITS-1:0]     rsp_box_top;
   logic signed [BOX_BITS-1:0]     rsp_box_width;
   logic signed [BOX_BITS-1:0]     rsp_box_height;
   logic [SCORE_BITS-1:0]          rsp_det_score;
   logic [CLASS_BITS-1:0]          rsp_class_index;
   logic                           csr_write_en;
   logic [CSR_INDEX_BITS-1:0]      csr_index;
   logic [CSR_DATA_BITS-1:0]       csr_wdata;

   box_scoreboard boxes = new;
   bit            sender_fast = 1'b0;
   bit            hold_request = 1'b0;
   int            items_sent = 0;
   int            idle_cycles = 0;

   detection_proposal_filter_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_attr_value  (req_attr_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_box_left    (rsp_box_left),
      .rsp_box_top     (rsp_box_top),
      .rsp_box_width   (rsp_box_width),
      .rsp_box_height  (rsp_box_height),
      .rsp_det_score   (rsp_det_score),
      .rsp_class_index (rsp_class_index),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         boxes.check_box('{rsp_box_left, rsp_box_top, rsp_box_width, rsp_box_height,
                           rsp_det_score, rsp_class_index});
   end

   // result side: a random stall, possibly none, before each transfer, with fast stretches and one long hold
   initial begin
      int hold;
      int left_in_mode;
      bit fast;
      left_in_mode = 0;
      fast = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         if (left_in_mode == 0) begin
            fast = ($urandom_range(0, 3) == 0);
            left_in_mode = $urandom_range(8, 40);
         end
         left_in_mode--;
         hold = fast ? 0 : $urandom_range(0, 16);
         if (hold_request) begin
            hold = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_attr(input attr_type value);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_attr_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      boxes.take_attr(value);
      items_sent++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      boxes.set_register(index, data);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // hold the sender until every box is out, then let rows that give none clear the pipe
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (boxes.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   function automatic attr_type extreme_attr();
      case ($urandom_range(0, 5))
         0:       return ATTR_MAX;
         1:       return ATTR_MIN;
         2:       return '0;
         3:       return -1;
         4:       return ONE_Q16;
         default: return -ONE_Q16;
      endcase
   endfunction

   function automatic attr_type pick_attr(logic [POS_BITS-1:0] pos, row_kind_type kind,
                                          logic [THR_BITS-1:0] thr);
      int r;
      r = $urandom_range(0, 99);
      if (kind == ROW_NOISE || r < 4) begin
         if ($urandom_range(0, 2) == 0) return extreme_attr();
         return $urandom;
      end
      case (pos)
         POS_CENTER_X, POS_CENTER_Y, POS_WIDTH, POS_HEIGHT: begin
            if (r < 12) return extreme_attr();
            return attr_type'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
         end
         POS_OBJECTNESS: begin
            if (kind == ROW_PASS) return ONE_Q16 + $urandom_range(0, 65536);
            if (r < 70) return thr + $urandom_range(0, 65536);
            if (r < 85) return thr - $urandom_range(1, 4096);
            return thr;
         end
         default: begin
            if (kind == ROW_PASS) return ONE_Q16 + $urandom_range(0, 32768);
            // a small set of values makes equal scores common
            if (r < 30) begin
               case ($urandom_range(0, 4))
                  0:       return '0;
                  1:       return 32'sd16384;
                  2:       return 32'sd32768;
                  3:       return ONE_Q16;
                  default: return 32'sd98304;
               endcase
            end
            if (r < 40) return -attr_type'($urandom_range(1, 65536));
            return $urandom_range(0, 98304);
         end
      endcase
   endfunction

   // send until the row closes, or stop after limit attributes and leave it open
   task automatic send_row(input row_kind_type kind, input int limit);
      int count;
      count = 0;
      do begin
         send_attr(pick_attr(boxes.position, kind, boxes.threshold));
         count++;
      end while (boxes.position != 0 && count < limit);
   endtask

   initial begin
      logic [THR_BITS-1:0] thr;
      logic [POS_BITS-1:0] len;
      int                  pick;
      int                  phase;
      int                  start;
      row_kind_type        kind;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_attr_value <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_SCORE_THRESHOLD;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // row length below the minimum acts as six, zero threshold
      write_register(CSR_ATTRIBUTES_PER_ROW, '0);
      write_register(CSR_SCORE_THRESHOLD, '0);
      // negative objectness fails even at zero threshold
      send_attr(ATTR_MAX); send_attr(ATTR_MIN); send_attr(ATTR_MIN);
      send_attr(ATTR_MAX); send_attr(ATTR_MIN); send_attr(ATTR_MIN);
      // saturated box fields and score
      send_attr(ATTR_MAX); send_attr(ATTR_MIN); send_attr(ATTR_MIN);
      send_attr(ATTR_MAX); send_attr(ATTR_MAX); send_attr(ATTR_MAX);
      // zero objectness with a negative class score still meets a zero threshold
      send_attr('0); send_attr(-1); send_attr(32'sd1);
      send_attr(-1); send_attr('0); send_attr(ATTR_MIN);
      wait_drained();
      // equal class scores exactly at a threshold of one: the first class wins
      write_register(CSR_SCORE_THRESHOLD, 17'd65536);
      write_register(CSR_ATTRIBUTES_PER_ROW, 17'd7);
      send_attr(3 * ONE_Q16); send_attr(5 * ONE_Q16); send_attr(2 * ONE_Q16);
      send_attr(-3 * ONE_Q16); send_attr(ONE_Q16); send_attr(ONE_Q16); send_attr(ONE_Q16);
      wait_drained();
      write_register(CSR_SPARE_2, 17'h1FFFF);
      write_register(CSR_SPARE_3, 17'h00005);

      phase = 0;
      while (items_sent < N_ITEMS) begin
         phase++;
         wait_drained();
         pick = $urandom_range(0, 9);
         case (pick)
            0:       thr = '0;
            1:       thr = 17'd65536;
            2:       thr = 17'h1FFFF;
            3:       thr = THR_RESET;
            default: thr = THR_BITS'($urandom_range(0, 65536));
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 70)      len = POS_BITS'($urandom_range(6, 12));
         else if (pick < 85) len = POS_BITS'($urandom_range(13, 40));
         else if (pick < 90) len = POS_BITS'($urandom_range(0, 5));
         else if (pick < 95) len = POS_BITS'(POS_FIRST_CLASS + MAX_CLASSES);
         else                len = POS_BITS'($urandom_range(262, 511));
         if (phase == PRESSURE_PHASE) begin
            thr = 17'd32768;
            len = LEN_MIN;
         end
         write_register(CSR_SCORE_THRESHOLD, thr);
         write_register(CSR_ATTRIBUTES_PER_ROW, CSR_DATA_BITS'(len));
         if ($urandom_range(0, 9) == 0)
            write_register($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                           CSR_DATA_BITS'($urandom));
         sender_fast = ($urandom_range(0, 3) == 0);
         if (phase == PRESSURE_PHASE) begin
            // stall results for a long stretch while rows keep coming back to back
            sender_fast = 1'b1;
            hold_request = 1'b1;
            repeat (30) send_row(ROW_PASS, 1000);
         end else begin
            start = items_sent;
            while (items_sent - start < 80) begin
               kind = ($urandom_range(0, 9) == 0) ? ROW_NOISE : ROW_MIXED;
               send_row(kind, 1000);
            end
            // leave a row open across the next register write
            if ($urandom_range(0, 2) == 0) send_row(ROW_MIXED, $urandom_range(1, 8));
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (boxes.mismatches == 0 && boxes.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
